FILE: hdl/brfle_pkg.sv
// ----------------------------------------------------------------------------
// brfle_pkg
// Types, codes and constants shared by the byte ring fifo with line extract.
// ----------------------------------------------------------------------------
package brfle_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam int unsigned DataW        = 8;
  localparam int unsigned OpW          = 2;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned LenW         = 5;
  localparam logic [DataW-1:0] TermReset = 8'd13;

  typedef enum logic [OpW-1:0] {
    OpPush    = 2'd0,
    OpPop     = 2'd1,
    OpGetLine = 2'd2,
    OpClear   = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StEmpty  = 2'd1,
    StNoLine = 2'd2,
    StFull   = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    ld_in;
    logic    push;
    logic    clr;
    logic    rd_rptr;
    logic    rd_scan;
    logic    pop_start;
    logic    scan_start;
    logic    scan_adv;
    logic    line_found;
    logic    emit_stat;
    logic    emit_pop;
    status_e stat;
  } brfle_cmd_t;

  // status from the datapath back to the controller
  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    match;
    logic    scan_last;
    logic    line_last;
    logic    out_free;
  } brfle_stat_t;

endpackage

FILE: hdl/brfle_in_if.sv
// ----------------------------------------------------------------------------
// brfle_in_if
// Request channel: opcode and data byte with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brfle_in_if;
  logic                        valid;
  logic                        ready;
  logic [brfle_pkg::OpW-1:0]   opcode;
  logic [brfle_pkg::DataW-1:0] data_in;

  modport source (output valid, output opcode, output data_in, input ready);
  modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

FILE: hdl/brfle_out_if.sv
// ----------------------------------------------------------------------------
// brfle_out_if
// Result channel: popped byte, status and fill information.
// ----------------------------------------------------------------------------
interface brfle_out_if;
  logic                          valid;
  logic                          ready;
  logic [brfle_pkg::DataW-1:0]   data_out;
  logic [brfle_pkg::StatusW-1:0] status;
  logic [brfle_pkg::LenW-1:0]    line_length;
  logic [brfle_pkg::LenW-1:0]    fill_level;
  logic                          full_flag;
  logic                          last;

  modport source (output valid, output data_out, output status, output line_length,
                  output fill_level, output full_flag, output last, input ready);
  modport sink   (input valid, input data_out, input status, input line_length,
                  input fill_level, input full_flag, input last, output ready);
endinterface

FILE: hdl/brfle_cfg_if.sv
// ----------------------------------------------------------------------------
// brfle_cfg_if
// Configuration write channel carrying the terminator byte.
// ----------------------------------------------------------------------------
interface brfle_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [brfle_pkg::DataW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/byte_ring_fifo_line_extract_core.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_line_extract_core
// Byte ring fifo with push, pop, clear and terminator-delimited line extract.
// ----------------------------------------------------------------------------
// push, clear and status-only requests: result registered once the output
//   register is free; next request taken only after a return to idle
// pop: registered storage read, then the byte goes to the output register
// get line: scanned bytes read then compared, line bytes read then emitted
// reset: pointers zero, terminator 13, storage contents left as they are
module byte_ring_fifo_line_extract_core #(
  parameter int unsigned DEPTH = brfle_pkg::DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brfle_in_if.sink    in_i,
  brfle_cfg_if.sink   cfg_i,
  brfle_out_if.source out_o
);
  import brfle_pkg::*;

  brfle_cmd_t  cmd;
  brfle_stat_t stat;
  logic        in_ready;

  assign in_i.ready = in_ready;

  brfle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  brfle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .opcode_i  (in_i.opcode),
    .data_in_i (in_i.data_in),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .cfg_i     (cfg_i),
    .out_o     (out_o)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  // a full ring never takes a byte
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !stat.full)
    else $error("push into full ring");

  // results only load into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_stat || cmd.emit_pop) |-> stat.out_free)
    else $error("result overwrote a pending result");

  // a byte is only popped when the ring holds one
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_pop |-> !stat.empty)
    else $error("pop from empty ring");

endmodule

FILE: hdl/brfle_ctrl.sv
// ----------------------------------------------------------------------------
// brfle_ctrl
// Sequencer for push, pop, line scan, line extraction and clear.
// ----------------------------------------------------------------------------
module brfle_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  brfle_pkg::brfle_stat_t stat_i,
  output brfle_pkg::brfle_cmd_t  cmd_o
);
  import brfle_pkg::*;

  localparam logic [2:0] SIdle     = 3'd0;
  localparam logic [2:0] SExec     = 3'd1;
  localparam logic [2:0] SScanRd   = 3'd2;
  localparam logic [2:0] SScanCmp  = 3'd3;
  localparam logic [2:0] SLineRd   = 3'd4;
  localparam logic [2:0] SLineEmit = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.stat = StOk;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = SExec;
        end
      end
      SExec: begin
        unique case (stat_i.op)
          OpPush: begin
            if (stat_i.out_free) begin
              cmd_o.emit_stat = 1'b1;
              if (stat_i.full) begin
                cmd_o.stat = StFull;
              end else begin
                cmd_o.push = 1'b1;
              end
              state_d = SIdle;
            end
          end
          OpClear: begin
            if (stat_i.out_free) begin
              cmd_o.clr       = 1'b1;
              cmd_o.emit_stat = 1'b1;
              state_d         = SIdle;
            end
          end
          OpPop: begin
            if (stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat      = StEmpty;
                state_d         = SIdle;
              end
            end else begin
              cmd_o.rd_rptr   = 1'b1;
              cmd_o.pop_start = 1'b1;
              state_d         = SLineEmit;
            end
          end
          OpGetLine: begin
            if (stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat      = StNoLine;
                state_d         = SIdle;
              end
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = SScanRd;
            end
          end
          default: state_d = SIdle;
        endcase
      end
      SScanRd: begin
        cmd_o.rd_scan = 1'b1;
        state_d       = SScanCmp;
      end
      SScanCmp: begin
        priority if (stat_i.match) begin
          cmd_o.line_found = 1'b1;
          state_d          = SLineRd;
        end else if (stat_i.scan_last) begin
          if (stat_i.out_free) begin
            cmd_o.emit_stat = 1'b1;
            cmd_o.stat      = StNoLine;
            state_d         = SIdle;
          end
        end else begin
          cmd_o.scan_adv = 1'b1;
          state_d        = SScanRd;
        end
      end
      SLineRd: begin
        cmd_o.rd_rptr = 1'b1;
        state_d       = SLineEmit;
      end
      SLineEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit_pop = 1'b1;
          state_d        = stat_i.line_last ? SIdle : SLineRd;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/brfle_dp.sv
// ----------------------------------------------------------------------------
// brfle_dp
// Byte storage, pointers, scan counters, terminator and result register.
// ----------------------------------------------------------------------------
module brfle_dp #(
  parameter int unsigned DEPTH = brfle_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [brfle_pkg::OpW-1:0]     opcode_i,
  input  logic [brfle_pkg::DataW-1:0]   data_in_i,
  input  brfle_pkg::brfle_cmd_t         cmd_i,
  output brfle_pkg::brfle_stat_t        stat_o,
  brfle_cfg_if.sink                     cfg_i,
  brfle_out_if.source                   out_o
);
  import brfle_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);

  logic [DataW-1:0] mem [DEPTH];
  logic [DataW-1:0] rdata_q;
  logic [DataW-1:0] din_q;
  logic [DataW-1:0] term_q;
  opcode_e          op_q;

  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [PtrW-1:0] scan_ptr_q;
  logic [PtrW-1:0] cnt_q;
  logic [PtrW-1:0] len_q;
  logic [PtrW-1:0] rem_q;
  logic            is_line_q;
  logic [PtrW-1:0] fill, fill_next, rd_addr;
  logic            emit;

  logic                out_valid_q;
  logic [DataW-1:0]    data_out_q;
  status_e             status_q;
  logic [LenW-1:0]     line_length_q;
  logic [LenW-1:0]     fill_level_q;
  logic                full_flag_q;
  logic                last_q;

  assign fill      = wptr_q - rptr_q;
  assign emit      = cmd_i.emit_stat | cmd_i.emit_pop;
  assign rd_addr   = cmd_i.rd_scan ? scan_ptr_q : rptr_q;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (cmd_i.clr) begin
      wptr_d = '0;
      rptr_d = '0;
    end else begin
      if (cmd_i.push)     wptr_d = wptr_q + 1'b1;
      if (cmd_i.emit_pop) rptr_d = rptr_q + 1'b1;
    end
  end

  // level seen by the result is the one after this transaction
  assign fill_next = wptr_d - rptr_d;

  assign stat_o.op        = op_q;
  assign stat_o.full      = (fill == {PtrW{1'b1}});
  assign stat_o.empty     = (fill == '0);
  assign stat_o.match     = (rdata_q == term_q);
  assign stat_o.scan_last = ((cnt_q + 1'b1) == fill);
  assign stat_o.line_last = (rem_q == PtrW'(1));
  assign stat_o.out_free  = !out_valid_q || out_o.ready;

  assign cfg_i.ready = 1'b1;

  // storage, no reset: only entries between the pointers are read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wptr_q] <= din_q;
    end
    if (cmd_i.rd_rptr || cmd_i.rd_scan) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      op_q  <= opcode_e'(opcode_i);
      din_q <= data_in_i;
    end
    if (emit) begin
      data_out_q    <= cmd_i.emit_pop ? rdata_q : '0;
      status_q      <= cmd_i.emit_pop ? StOk : cmd_i.stat;
      line_length_q <= (cmd_i.emit_pop && is_line_q) ? LenW'(len_q) : '0;
      fill_level_q  <= LenW'(fill_next);
      full_flag_q   <= (fill_next == {PtrW{1'b1}});
      last_q        <= cmd_i.emit_pop ? (rem_q == PtrW'(1)) : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      scan_ptr_q  <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      is_line_q   <= 1'b0;
      term_q      <= TermReset;
      out_valid_q <= 1'b0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      if (cfg_i.valid) begin
        term_q <= cfg_i.data;
      end
      if (cmd_i.scan_start) begin
        scan_ptr_q <= rptr_q;
        cnt_q      <= '0;
      end else if (cmd_i.scan_adv) begin
        scan_ptr_q <= scan_ptr_q + 1'b1;
        cnt_q      <= cnt_q + 1'b1;
      end
      if (cmd_i.pop_start) begin
        rem_q     <= PtrW'(1);
        is_line_q <= 1'b0;
      end else if (cmd_i.line_found) begin
        len_q     <= cnt_q + 1'b1;
        rem_q     <= cnt_q + 1'b1;
        is_line_q <= 1'b1;
      end else if (cmd_i.emit_pop) begin
        rem_q <= rem_q - 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.data_out    = data_out_q;
  assign out_o.status      = status_q;
  assign out_o.line_length = line_length_q;
  assign out_o.fill_level  = fill_level_q;
  assign out_o.full_flag   = full_flag_q;
  assign out_o.last        = last_q;

endmodule

FILE: test/byte_ring_fifo_line_extract_core_test.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_line_extract_core_test
// Self-checking bench for the byte ring fifo: push, pop, get-line and clear
// requests go in through a bursty sender, results come back through a stalling
// receiver and are compared field by field with an in-bench ring predictor.
// ----------------------------------------------------------------------------
module byte_ring_fifo_line_extract_core_test;
  import brfle_pkg::*;

  localparam int unsigned Depth      = DepthDefault;
  localparam int unsigned PtrW       = $clog2(Depth);
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 40;

  typedef struct {
    logic [DataW-1:0] data;
    status_e          status;
    logic [LenW-1:0]  len;
    logic [LenW-1:0]  fill;
    logic             full;
    logic             last;
  } ring_result_t;

  logic clk;
  logic rst_n;

  brfle_in_if  in_if();
  brfle_cfg_if cfg_if();
  brfle_out_if out_if();

  byte_ring_fifo_line_extract_core #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // predictor state
  logic [DataW-1:0] ring_mem [Depth];
  logic [PtrW-1:0]  ring_rd;
  logic [PtrW-1:0]  ring_wr;
  logic [DataW-1:0] line_term;
  ring_result_t     pending_results[$];

  int unsigned n_sent;
  int unsigned burst_left;
  int unsigned op_count [4];
  int unsigned n_results;
  int unsigned n_lines;
  int unsigned longest_line;
  int unsigned n_dropped;
  int unsigned n_empty;
  int unsigned n_noline;
  int unsigned n_term_writes;
  int unsigned n_errors;
  int unsigned stall_cnt;
  int unsigned stall_mode;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.opcode   = OpPush;
    in_if.data_in  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    out_if.ready   = 1'b0;
    ring_rd        = '0;
    ring_wr        = '0;
    line_term      = TermReset;
    foreach (ring_mem[i]) ring_mem[i] = '0;
  end

  function automatic logic [PtrW-1:0] ring_fill();
    return ring_wr - ring_rd;
  endfunction

  task automatic expect_result(input logic [DataW-1:0] data, input status_e status,
                               input int unsigned len, input logic last);
    ring_result_t r;
    r.data   = data;
    r.status = status;
    r.len    = LenW'(len);
    r.fill   = LenW'(ring_fill());
    r.full   = (ring_fill() == PtrW'(Depth - 1));
    r.last   = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_request(input opcode_e op, input logic [DataW-1:0] din);
    logic [PtrW-1:0]  p;
    logic [DataW-1:0] b;
    int unsigned      n;
    int unsigned      len;
    case (op)
      OpPush: begin
        if (ring_fill() == PtrW'(Depth - 1)) begin
          expect_result('0, StFull, 0, 1'b1);
        end else begin
          ring_mem[ring_wr] = din;
          ring_wr++;
          expect_result('0, StOk, 0, 1'b1);
        end
      end
      OpPop: begin
        if (ring_fill() == '0) begin
          expect_result('0, StEmpty, 0, 1'b1);
        end else begin
          b = ring_mem[ring_rd];
          ring_rd++;
          expect_result(b, StOk, 0, 1'b1);
        end
      end
      OpGetLine: begin
        n   = 32'(ring_fill());
        p   = ring_rd;
        len = 0;
        for (int i = 0; i < n; i++) begin
          if (ring_mem[p] == line_term) begin
            len = i + 1;
            break;
          end
          p++;
        end
        if (len == 0) begin
          expect_result('0, StNoLine, 0, 1'b1);
        end else begin
          for (int k = 0; k < len; k++) begin
            b = ring_mem[ring_rd];
            ring_rd++;
            expect_result(b, StOk, len, k + 1 == len);
          end
        end
      end
      default: begin
        ring_rd = '0;
        ring_wr = '0;
        foreach (ring_mem[i]) ring_mem[i] = '0;
        expect_result('0, StOk, 0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string fname, input int unsigned idx,
                             input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_errors++;
      if (n_errors <= MaxReports)
        $display("%0t: result %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, idx, fname, want, got);
    end
  endtask

  // predicts on accepted requests, tracks the terminator and checks results
  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) line_term = cfg_if.data;
      if (in_if.valid && in_if.ready) begin
        op_count[in_if.opcode]++;
        predict_request(opcode_e'(in_if.opcode), in_if.data_in);
      end
      if (out_if.valid && out_if.ready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("%0t: result %0d with nothing expected, data 0x%0h status %0d",
                     $time, n_results, out_if.data_out, out_if.status);
        end else begin
          want = pending_results.pop_front();
          check_field("data_out", n_results, 32'(want.data), 32'(out_if.data_out));
          check_field("status", n_results, 32'(want.status), 32'(out_if.status));
          check_field("line_length", n_results, 32'(want.len),
                      32'(out_if.line_length));
          check_field("fill_level", n_results, 32'(want.fill),
                      32'(out_if.fill_level));
          check_field("full_flag", n_results, 32'(want.full), 32'(out_if.full_flag));
          check_field("last", n_results, 32'(want.last), 32'(out_if.last));
          case (want.status)
            StFull:   n_dropped++;
            StEmpty:  n_empty++;
            StNoLine: n_noline++;
            default: begin
              if (want.last && want.len != 0) begin
                n_lines++;
                if (32'(want.len) > longest_line) longest_line = 32'(want.len);
              end
            end
          endcase
        end
      end
    end
  end

  // receiver stall pattern, in one of four characters drawn at random
  always @(negedge clk) begin
    if (rst_n) begin
      stall_cnt++;
      if (stall_cnt % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0:       out_if.ready = 1'b1;
        1:       out_if.ready = 1'($urandom_range(0, 1));
        2:       out_if.ready = (stall_cnt % 3 == 0);
        default: out_if.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // entered and left at a falling edge; valid stays high into the next call
  task automatic send_request(input opcode_e op, input logic [DataW-1:0] din);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_if.valid   = 1'b1;
    in_if.opcode  = op;
    in_if.data_in = din;
    do @(posedge clk); while (!in_if.ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_terminator(input logic [DataW-1:0] value);
    wait_idle();
    cfg_if.valid = 1'b1;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    n_term_writes++;
  endtask

  function automatic logic [DataW-1:0] plain_byte();
    logic [DataW-1:0] b;
    b = DataW'($urandom_range(0, 255));
    if (b == line_term) b = ~b;
    return b;
  endfunction

  function automatic logic [DataW-1:0] any_byte();
    return DataW'($urandom_range(0, 255));
  endfunction

  task automatic test_basic_ops();
    write_terminator(TermReset);
    send_request(OpPop, 8'hff);
    send_request(OpGetLine, 8'h00);
    send_request(OpPush, 8'h00);
    send_request(OpPush, 8'hff);
    send_request(OpPush, 8'h41);
    send_request(OpGetLine, 8'h5a);
    send_request(OpPush, TermReset);
    send_request(OpPush, 8'h55);
    send_request(OpGetLine, 8'ha5);
    send_request(OpPop, 8'h00);
    send_request(OpPop, 8'h00);
    // terminator as the oldest byte gives a one-byte line
    send_request(OpPush, TermReset);
    send_request(OpGetLine, 8'h00);
    send_request(OpPush, 8'haa);
    send_request(OpPush, 8'h01);
    send_request(OpClear, 8'hff);
    send_request(OpPop, 8'h00);
    send_request(OpGetLine, 8'h00);
  endtask

  task automatic test_terminator_extremes();
    write_terminator(8'h00);
    send_request(OpPush, 8'h05);
    send_request(OpPush, 8'h00);
    send_request(OpPush, 8'h00);
    send_request(OpGetLine, 8'hff);
    send_request(OpGetLine, 8'hff);
    send_request(OpGetLine, 8'hff);
    write_terminator(8'hff);
    send_request(OpPush, 8'hff);
    send_request(OpPush, 8'h07);
    send_request(OpGetLine, 8'h00);
    send_request(OpPop, 8'h00);
  endtask

  task automatic test_full_ring();
    write_terminator(DataW'($urandom_range(1, 254)));
    send_request(OpClear, any_byte());
    // longest possible line: terminator in the last free slot
    for (int i = 0; i < Depth - 2; i++) send_request(OpPush, plain_byte());
    send_request(OpPush, line_term);
    send_request(OpPush, any_byte());
    send_request(OpGetLine, any_byte());
    // full ring with no terminator, then a pop from full
    for (int i = 0; i < Depth - 1; i++) send_request(OpPush, plain_byte());
    send_request(OpPush, line_term);
    send_request(OpGetLine, any_byte());
    send_request(OpPop, any_byte());
    send_request(OpPush, any_byte());
    send_request(OpClear, any_byte());
  endtask

  task automatic test_random_lines(input logic [DataW-1:0] term, input int unsigned quota);
    int unsigned start;
    int unsigned choice;
    int unsigned len;
    write_terminator(term);
    start = n_sent;
    while (n_sent - start < quota) begin
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
        for (int i = 0; i < len; i++)
          send_request(OpPush, ($urandom_range(0, 11) == 0) ? line_term : plain_byte());
        if ($urandom_range(0, 7) != 0) send_request(OpPush, line_term);
        send_request(OpGetLine, any_byte());
        if ($urandom_range(0, 4) == 0) send_request(OpGetLine, any_byte());
      end else if (choice < 85) begin
        repeat ($urandom_range(1, 4)) send_request(OpPop, any_byte());
      end else if (choice < 97) begin
        send_request(opcode_e'($urandom_range(0, 3)), any_byte());
      end else begin
        send_request(OpClear, any_byte());
      end
    end
  endtask

  initial begin : run
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    test_terminator_extremes();
    test_full_ring();
    test_random_lines(8'h0a, 72);
    test_random_lines(any_byte(), 72);
    test_random_lines(8'h00, 72);
    test_random_lines(8'hff, 72);
    test_random_lines(TermReset, 72);

    wait_idle();
    repeat (40) @(posedge clk);

    $display("covered %0d requests (%0d push, %0d pop, %0d get-line, %0d clear), %0d results",
             n_sent, op_count[OpPush], op_count[OpPop], op_count[OpGetLine],
             op_count[OpClear], n_results);
    $display("%0d lines (longest %0d), %0d full drops, %0d empty pops, %0d scans w/o line",
             n_lines, longest_line, n_dropped, n_empty, n_noline);
    $display("%0d terminator writes", n_term_writes);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/brfle_pkg.sv
hdl/brfle_in_if.sv
hdl/brfle_out_if.sv
hdl/brfle_cfg_if.sv
hdl/brfle_ctrl.sv
hdl/brfle_dp.sv
hdl/byte_ring_fifo_line_extract_core.sv
test/byte_ring_fifo_line_extract_core_test.sv
